// ===== rtl/rvr_pkg.sv =====
// Shared types, register codes and saturation helper for the rotor vector
// rotation block. No dependencies.

package rvr_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned PROD_W   = 34;  // 64-bit product shifted right by 30
  localparam int unsigned ACC_W    = 36;  // room for sums of up to four shifted products
  localparam int unsigned Q_SHIFT  = 30;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned NUM_DIM  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_SCALAR = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_XY     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_YZ     = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_ZX     = CFG_IDX_W'(3);

  localparam logic signed [WORD_W-1:0] ROTOR_ONE = WORD_W'(32'sd1 <<< Q_SHIFT);
  localparam logic signed [WORD_W-1:0] WORD_MAX  = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic signed [WORD_W-1:0] WORD_MIN  = {1'b1, {(WORD_W-1){1'b0}}};

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef word_t [NUM_DIM-1:0]      vec3_t;
  typedef vec3_t [NUM_DIM-1:0]      mat_t;
  typedef acc_t  [NUM_DIM-1:0]      acc3_t;

  typedef struct packed {
    logic hit;
    word_t val;
  } sat_t;

  // Stage load enables of the datapath pipeline
  typedef struct packed {
    logic mul_en;
    logic sum_en;
    logic out_en;
  } stage_en_t;

  function automatic sat_t sat_word(input acc_t x);
    sat_t r;
    logic [ACC_W-WORD_W:0] top;
    top = x[ACC_W-1:WORD_W-1];
    if (top == '0 || top == '1) begin
      r.hit = 1'b0;
      r.val = x[WORD_W-1:0];
    end else begin
      r.hit = 1'b1;
      r.val = x[ACC_W-1] ? WORD_MIN : WORD_MAX;
    end
    return r;
  endfunction

  function automatic acc_t ext_prod(input prod_t p);
    return {{(ACC_W-PROD_W){p[PROD_W-1]}}, p};
  endfunction

endpackage

// ===== rtl/rvr_matrix.sv =====
// Rotor registers and rotation-matrix builder.
// Depends on rvr_pkg. A write passes product and matrix registers.

module rvr_matrix import rvr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  word_t                cfg_data_i,
  output mat_t                 mat_o
);

  localparam int unsigned NUM_PROD = 10;
  localparam int unsigned P_SS = 0, P_AA = 1, P_BB = 2, P_CC = 3, P_SA = 4;
  localparam int unsigned P_SB = 5, P_SC = 6, P_AB = 7, P_AC = 8, P_BC = 9;

  word_t s_q, a_q, b_q, c_q;
  prod_t prod_q [NUM_PROD];
  logic signed [2*WORD_W-1:0] full [NUM_PROD];
  mat_t  mat_d, mat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q <= ROTOR_ONE;
      a_q <= '0;
      b_q <= '0;
      c_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_SCALAR: s_q <= cfg_data_i;
        REG_XY:     a_q <= cfg_data_i;
        REG_YZ:     b_q <= cfg_data_i;
        REG_ZX:     c_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign full[P_SS] = s_q * s_q;
  assign full[P_AA] = a_q * a_q;
  assign full[P_BB] = b_q * b_q;
  assign full[P_CC] = c_q * c_q;
  assign full[P_SA] = s_q * a_q;
  assign full[P_SB] = s_q * b_q;
  assign full[P_SC] = s_q * c_q;
  assign full[P_AB] = a_q * b_q;
  assign full[P_AC] = a_q * c_q;
  assign full[P_BC] = b_q * c_q;

  // floor shift by 30 is the arithmetic upper slice
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NUM_PROD; k++) begin
      prod_q[k] <= full[k][2*WORD_W-1:Q_SHIFT];
    end
  end

  always_comb begin
    acc_t ss, aa, bb, cc, sa, sb, sc, ab, ac, bc;
    acc_t raw [NUM_DIM][NUM_DIM];
    sat_t ent;
    ss = ext_prod(prod_q[P_SS]);
    aa = ext_prod(prod_q[P_AA]);
    bb = ext_prod(prod_q[P_BB]);
    cc = ext_prod(prod_q[P_CC]);
    sa = ext_prod(prod_q[P_SA]);
    sb = ext_prod(prod_q[P_SB]);
    sc = ext_prod(prod_q[P_SC]);
    ab = ext_prod(prod_q[P_AB]);
    ac = ext_prod(prod_q[P_AC]);
    bc = ext_prod(prod_q[P_BC]);
    raw[0][0] = ss - aa + bb - cc;
    raw[0][1] = (sa + bc) <<< 1;
    raw[0][2] = (ab - sc) <<< 1;
    raw[1][0] = (bc - sa) <<< 1;
    raw[1][1] = ss - aa - bb + cc;
    raw[1][2] = (ac + sb) <<< 1;
    raw[2][0] = (ab + sc) <<< 1;
    raw[2][1] = (ac - sb) <<< 1;
    raw[2][2] = ss + aa - bb - cc;
    // out-of-range entries clamp without raising the output flag
    for (int i = 0; i < NUM_DIM; i++) begin
      for (int j = 0; j < NUM_DIM; j++) begin
        ent         = sat_word(raw[i][j]);
        mat_d[i][j] = ent.val;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mat_q <= mat_d;
  end

  assign mat_o = mat_q;

endmodule

// ===== rtl/rvr_lane.sv =====
// One output row: three entry-by-component products, then their sum.
// Depends on rvr_pkg.

module rvr_lane import rvr_pkg::*; (
  input  logic      clk_i,
  input  stage_en_t en_i,
  input  vec3_t     row_i,
  input  vec3_t     vec_i,
  output acc_t      sum_o
);

  logic signed [2*WORD_W-1:0] full [NUM_DIM];
  prod_t prod_q [NUM_DIM];
  acc_t  sum_q;

  always_comb begin
    for (int j = 0; j < NUM_DIM; j++) begin
      full[j] = $signed(row_i[j]) * $signed(vec_i[j]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.mul_en) begin
      for (int j = 0; j < NUM_DIM; j++) begin
        prod_q[j] <= full[j][2*WORD_W-1:Q_SHIFT];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.sum_en) begin
      sum_q <= ext_prod(prod_q[0]) + ext_prod(prod_q[1]) + ext_prod(prod_q[2]);
    end
  end

  assign sum_o = sum_q;

endmodule

// ===== rtl/rvr_merge.sv =====
// Merging stage: saturates the lane sums, combines the clip flags and
// registers the result. Depends on rvr_pkg.

module rvr_merge import rvr_pkg::*; (
  input  logic      clk_i,
  input  stage_en_t en_i,
  input  acc3_t     sum_i,
  output vec3_t     rot_o,
  output logic      clipped_o
);

  vec3_t rot_d, rot_q;
  logic  clip_d, clip_q;

  always_comb begin
    sat_t r;
    clip_d = 1'b0;
    for (int i = 0; i < NUM_DIM; i++) begin
      r        = sat_word(sum_i[i]);
      rot_d[i] = r.val;
      clip_d   = clip_d | r.hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.out_en) begin
      rot_q  <= rot_d;
      clip_q <= clip_d;
    end
  end

  assign rot_o     = rot_q;
  assign clipped_o = clip_q;

endmodule

// ===== rtl/rotor_vector_rotation.sv =====
// Top level of the rotor vector rotation block: stream ports, pipeline
// control, matrix builder, three row lanes and the merging stage.
// Depends on rvr_pkg, rvr_matrix, rvr_lane, rvr_merge.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-------------------------------------
//  s_axis   | in        | tvalid / tready    | tdata: vec_x, vec_y, vec_z
//  m_axis   | out       | tvalid / tready    | tdata: rot_x, rot_y, rot_z; tuser: clipped
//  cfg      | in        | valid / ready      | index (0..3 used), data (Q2.30)
//
// One vector per cycle unless m_axis stalls or the matrix is rebuilding;
// vectors pass the product, row sum and saturate registers in turn. After
// each register write, and after reset, the matrix is rebuilt and
// s_axis_tready_o stays low until it is done. A stalled output backs up
// the pipeline one stage at a time, so holes are filled before input is refused.

module rotor_vector_rotation import rvr_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [3*WORD_W-1:0]    s_axis_tdata_i,   // vec_x, vec_y, vec_z
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [3*WORD_W-1:0]    m_axis_tdata_o,   // rot_x, rot_y, rot_z
  output logic [0:0]             m_axis_tuser_o,   // clipped
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [WORD_W-1:0]      cfg_data_i
);

  localparam logic [1:0] REBUILD_CYCLES = 2'd2;

  logic [1:0] busy_q, busy_d;
  logic       v_mul_q, v_sum_q, v_out_q;
  logic       cfg_we, in_xfer;
  stage_en_t  en;
  mat_t       mat;
  vec3_t      vec, rot;
  acc3_t      sums;
  logic       clipped;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  always_comb begin
    busy_d = busy_q;
    if (cfg_we) begin
      busy_d = REBUILD_CYCLES;
    end else if (busy_q != '0) begin
      busy_d = busy_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= REBUILD_CYCLES;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_comb begin
    en.out_en = ~v_out_q | m_axis_tready_i;
    en.sum_en = ~v_sum_q | en.out_en;
    en.mul_en = ~v_mul_q | en.sum_en;
  end

  assign s_axis_tready_o = en.mul_en & (busy_q == '0);
  assign in_xfer         = s_axis_tvalid_i & s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_mul_q <= 1'b0;
      v_sum_q <= 1'b0;
      v_out_q <= 1'b0;
    end else begin
      if (en.mul_en) v_mul_q <= in_xfer;
      if (en.sum_en) v_sum_q <= v_mul_q;
      if (en.out_en) v_out_q <= v_sum_q;
    end
  end

  always_comb begin
    for (int j = 0; j < NUM_DIM; j++) begin
      vec[j] = s_axis_tdata_i[j*WORD_W +: WORD_W];
    end
  end

  rvr_matrix u_matrix (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .mat_o       (mat)
  );

  for (genvar i = 0; i < NUM_DIM; i++) begin : g_lane
    rvr_lane u_lane (
      .clk_i (clk_i),
      .en_i  (en),
      .row_i (mat[i]),
      .vec_i (vec),
      .sum_o (sums[i])
    );
  end

  rvr_merge u_merge (
    .clk_i     (clk_i),
    .en_i      (en),
    .sum_i     (sums),
    .rot_o     (rot),
    .clipped_o (clipped)
  );

  assign m_axis_tvalid_o = v_out_q;
  assign m_axis_tuser_o  = clipped;

  always_comb begin
    for (int i = 0; i < NUM_DIM; i++) begin
      m_axis_tdata_o[i*WORD_W +: WORD_W] = rot[i];
    end
  end

endmodule
